[hdl/calendar_date_sequence_top_assert.svh]
// Assertion macros for the port-level checker of the date sequencer.
`ifndef CALENDAR_DATE_SEQUENCE_TOP_ASSERT_SVH
`define CALENDAR_DATE_SEQUENCE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CDS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("date sequencer check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("date sequencer check failed");

`endif

[hdl/cds_pkg.sv]
// Shared widths, calendar constants and control structs of the date sequencer.
package cds_pkg;

  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_IO_W = 16;
  localparam int COUNT_W   = 6;
  localparam int REM_W     = 9;

  localparam logic [REM_W-1:0] LEAP_CYCLE = 9'd400;
  localparam logic [REM_W-1:0] CENTURY    = 9'd100;

  localparam logic [MONTH_W-1:0] JAN = 4'd1;
  localparam logic [MONTH_W-1:0] FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MAR = 4'd3;
  localparam logic [MONTH_W-1:0] APR = 4'd4;
  localparam logic [MONTH_W-1:0] MAY = 4'd5;
  localparam logic [MONTH_W-1:0] JUN = 4'd6;
  localparam logic [MONTH_W-1:0] JUL = 4'd7;
  localparam logic [MONTH_W-1:0] AUG = 4'd8;
  localparam logic [MONTH_W-1:0] SEP = 4'd9;
  localparam logic [MONTH_W-1:0] OCT = 4'd10;
  localparam logic [MONTH_W-1:0] NOV = 4'd11;
  localparam logic [MONTH_W-1:0] DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAYS_FEB  = 5'd28;
  localparam logic [DAY_W-1:0] DAYS_LEAP = 5'd29;
  localparam logic [DAY_W-1:0] DAYS_30   = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_31   = 5'd31;
  localparam logic [DAY_W-1:0] FIRST_DAY = 5'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic echo;
    logic rem_calc;
    logic step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic rem_last;
    logic steps_zero;
    logic steps_one;
    logic step_bad;
  } dp_status_t;

  // Leap test from the year modulo 400.
  function automatic logic leap_from_rem(input logic [REM_W-1:0] r);
    leap_from_rem = (r[1:0] == 2'b00) && (r != CENTURY) &&
                    (r != 9'(2 * CENTURY)) && (r != 9'(3 * CENTURY));
  endfunction

  // Days in a month, zero for a month code outside the calendar.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    case (m) inside
      JAN, MAR, MAY, JUL, AUG, OCT, DEC: month_len = DAYS_31;
      APR, JUN, SEP, NOV:                month_len = DAYS_30;
      FEB:                               month_len = leap ? DAYS_LEAP : DAYS_FEB;
      default:                           month_len = '0;
    endcase
  endfunction

endpackage

[hdl/cds_if.sv]
// Valid/ready channel interfaces for start requests and emitted dates.
interface cds_in_if;
  logic                              valid;
  logic                              ready;
  logic [cds_pkg::DAY_W-1:0]         start_day;
  logic [cds_pkg::MONTH_W-1:0]       start_month;
  logic [cds_pkg::YEAR_IO_W-1:0]     start_year;
  logic [cds_pkg::COUNT_W-1:0]       count;

  modport source (output valid, start_day, start_month, start_year, count,
                  input ready);
  modport sink   (input valid, start_day, start_month, start_year, count,
                  output ready);
endinterface

interface cds_out_if;
  logic                              valid;
  logic                              ready;
  logic [cds_pkg::DAY_W-1:0]         out_day;
  logic [cds_pkg::MONTH_W-1:0]       out_month;
  logic [cds_pkg::YEAR_IO_W-1:0]     out_year;
  logic                              invalid;
  logic                              last;

  modport source (output valid, out_day, out_month, out_year, invalid, last,
                  input ready);
  modport sink   (input valid, out_day, out_month, out_year, invalid, last,
                  output ready);
endinterface

[hdl/calendar_date_sequence_top.sv]
// Top level of the Gregorian date sequencer: controller plus datapath.
//
//   channel  | dir | transfer carries
//   ---------+-----+--------------------------------------------------
//   in_ch    | in  | start_day, start_month, start_year, count
//   out_ch   | out | out_day, out_month, out_year, invalid, last
//
// A request is loaded, its start date echoed, the year modulo 400 found by
// the remainder unit (reciprocal multiply, then multiply back and subtract),
// and then one date is emitted per cycle while the output is not stalled, as
// many as the count saturated at MAX_COUNT. A zero count skips the remainder.
// A check failure ends the run early.
// Reset is synchronous, active low, and leaves the block idle and ready.
// A stalled output holds its result; stepping waits until it is taken.
module calendar_date_sequence_top #(
  parameter int MAX_COUNT  = 63,
  parameter int YEAR_WIDTH = 16
) (
  input logic      clk,
  input logic      rst_n,
  cds_in_if.sink   in_ch,
  cds_out_if.source out_ch
);

  cds_pkg::ctrl_cmd_t  cmd;
  cds_pkg::dp_status_t status;

  cds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  cds_dpath #(
    .MAX_COUNT  (MAX_COUNT),
    .YEAR_WIDTH (YEAR_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .start_day   (in_ch.start_day),
    .start_month (in_ch.start_month),
    .start_year  (in_ch.start_year),
    .count       (in_ch.count),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_day     (out_ch.out_day),
    .out_month   (out_ch.out_month),
    .out_year    (out_ch.out_year),
    .out_invalid (out_ch.invalid),
    .out_last    (out_ch.last)
  );

endmodule

[hdl/cds_ctrl.sv]
// Run controller: sequences request load, echo, year remainder and date steps.
module cds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cds_pkg::dp_status_t status,
  output cds_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ECHO,
    S_REM,
    S_STEP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_ECHO;
        end
      end
      S_ECHO: begin
        if (status.out_free) begin
          cmd.echo  = 1'b1;
          state_nxt = status.steps_zero ? S_IDLE : S_REM;
        end
      end
      S_REM: begin
        cmd.rem_calc = 1'b1;
        if (status.rem_last) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.step_bad || status.steps_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  // Hold state and the registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

[hdl/cds_dpath.sv]
// Date datapath: current date, step counter, year-mod-400 unit and output register.
module cds_dpath #(
  parameter int MAX_COUNT  = 63,
  parameter int YEAR_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cds_pkg::ctrl_cmd_t                cmd,
  output cds_pkg::dp_status_t               status,
  input  logic [cds_pkg::DAY_W-1:0]         start_day,
  input  logic [cds_pkg::MONTH_W-1:0]       start_month,
  input  logic [cds_pkg::YEAR_IO_W-1:0]     start_year,
  input  logic [cds_pkg::COUNT_W-1:0]       count,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [cds_pkg::DAY_W-1:0]         out_day,
  output logic [cds_pkg::MONTH_W-1:0]       out_month,
  output logic [cds_pkg::YEAR_IO_W-1:0]     out_year,
  output logic                              out_invalid,
  output logic                              out_last
);

  // Year / 400 as (year >> 4) / 25; the reciprocal of 25 with Q_W + 5
  // fraction bits is exact for every Q_W-bit operand.
  localparam int Q_W = YEAR_WIDTH - 4;
  localparam int M_W = Q_W + 1;
  localparam int P_W = Q_W + M_W;
  localparam int SH  = Q_W + 5;
  localparam logic [M_W-1:0] RECIP25 = M_W'(((64'd1 << SH) + 64'd24) / 64'd25);
  localparam logic [cds_pkg::COUNT_W-1:0] MAX_STEPS = cds_pkg::COUNT_W'(MAX_COUNT);
  localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = {YEAR_WIDTH{1'b1}};

  logic [cds_pkg::DAY_W-1:0]     day_r, day_nxt;
  logic [cds_pkg::MONTH_W-1:0]   month_r, month_nxt;
  logic [YEAR_WIDTH-1:0]         year_r, year_nxt;
  logic [cds_pkg::COUNT_W-1:0]   steps_r, steps_nxt;
  logic [cds_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic [Q_W-1:0]                q_r, q_nxt;
  logic                          rem_phase_r, rem_phase_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [cds_pkg::DAY_W-1:0]     oday_r, oday_nxt;
  logic [cds_pkg::MONTH_W-1:0]   omonth_r, omonth_nxt;
  logic [YEAR_WIDTH-1:0]         oyear_r, oyear_nxt;
  logic                          oinv_r, oinv_nxt;
  logic                          olast_r, olast_nxt;

  logic [P_W-1:0]                prod;
  logic                          leap;
  logic [cds_pkg::DAY_W-1:0]     mlen;
  logic                          bad;
  logic [cds_pkg::DAY_W-1:0]     step_day;
  logic [cds_pkg::MONTH_W-1:0]   step_month;
  logic [YEAR_WIDTH-1:0]         step_year;
  logic [cds_pkg::REM_W-1:0]     step_rem;

  // Reciprocal product of the year's upper bits
  assign prod = P_W'(year_r[YEAR_WIDTH-1:4]) * P_W'(RECIP25);

  // Check the current date and form the following one
  always_comb begin
    leap = cds_pkg::leap_from_rem(rem_r);
    mlen = cds_pkg::month_len(month_r, leap);
    bad  = (year_r == '0) || (mlen == '0) || (day_r == '0) || (day_r > mlen) ||
           ((month_r == cds_pkg::DEC) && (day_r == cds_pkg::DAYS_31) &&
            (year_r == YEAR_MAX));
    step_day   = day_r;
    step_month = month_r;
    step_year  = year_r;
    step_rem   = rem_r;
    if (day_r < mlen) begin
      step_day = day_r + 1'b1;
    end else begin
      step_day = cds_pkg::FIRST_DAY;
      if (month_r == cds_pkg::DEC) begin
        step_month = cds_pkg::JAN;
        step_year  = year_r + 1'b1;
        step_rem   = (rem_r == cds_pkg::LEAP_CYCLE - 1'b1) ? '0 : rem_r + 1'b1;
      end else begin
        step_month = month_r + 1'b1;
      end
    end
  end

  // Next values of the run registers and the output register
  always_comb begin
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    steps_nxt     = steps_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    rem_phase_nxt = rem_phase_r;
    oday_nxt      = oday_r;
    omonth_nxt    = omonth_r;
    oyear_nxt     = oyear_r;
    oinv_nxt      = oinv_r;
    olast_nxt     = olast_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load) begin
      day_nxt       = start_day;
      month_nxt     = start_month;
      year_nxt      = YEAR_WIDTH'(start_year);
      steps_nxt     = (count > MAX_STEPS) ? MAX_STEPS : count;
      rem_nxt       = '0;
      rem_phase_nxt = 1'b0;
    end

    // Quotient phase: quotient by 400; remainder phase: subtract 400 times it, mod 512
    if (cmd.rem_calc) begin
      if (!rem_phase_r) begin
        q_nxt         = Q_W'(prod >> SH);
        rem_phase_nxt = 1'b1;
      end else begin
        rem_nxt       = year_r[cds_pkg::REM_W-1:0] -
                        cds_pkg::REM_W'(cds_pkg::REM_W'(q_r) * cds_pkg::LEAP_CYCLE);
        rem_phase_nxt = 1'b0;
      end
    end

    // Echo the start date unchecked
    if (cmd.echo) begin
      out_valid_nxt = 1'b1;
      oday_nxt      = day_r;
      omonth_nxt    = month_r;
      oyear_nxt     = year_r;
      oinv_nxt      = 1'b0;
      olast_nxt     = (steps_r == '0);
    end

    // Emit the failing date, or advance one day and emit it
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
      if (bad) begin
        oday_nxt   = day_r;
        omonth_nxt = month_r;
        oyear_nxt  = year_r;
        oinv_nxt   = 1'b1;
        olast_nxt  = 1'b1;
        steps_nxt  = '0;
      end else begin
        day_nxt    = step_day;
        month_nxt  = step_month;
        year_nxt   = step_year;
        rem_nxt    = step_rem;
        steps_nxt  = steps_r - 1'b1;
        oday_nxt   = step_day;
        omonth_nxt = step_month;
        oyear_nxt  = step_year;
        oinv_nxt   = 1'b0;
        olast_nxt  = (steps_r == cds_pkg::COUNT_W'(1));
      end
    end
  end

  // Hold control state under reset, payload without
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      steps_r     <= '0;
      rem_phase_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      steps_r     <= steps_nxt;
      rem_phase_r <= rem_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    day_r    <= day_nxt;
    month_r  <= month_nxt;
    year_r   <= year_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    oday_r   <= oday_nxt;
    omonth_r <= omonth_nxt;
    oyear_r  <= oyear_nxt;
    oinv_r   <= oinv_nxt;
    olast_r  <= olast_nxt;
  end

  always_comb begin
    status.out_free   = !out_valid_r || out_ready;
    status.rem_last   = rem_phase_r;
    status.steps_zero = (steps_r == '0);
    status.steps_one  = (steps_r == cds_pkg::COUNT_W'(1));
    status.step_bad   = bad;
  end

  assign out_valid   = out_valid_r;
  assign out_day     = oday_r;
  assign out_month   = omonth_r;
  assign out_year    = cds_pkg::YEAR_IO_W'(oyear_r);
  assign out_invalid = oinv_r;
  assign out_last    = olast_r;

endmodule

[hdl/cds_checker.sv]
// Port-level checker for the date sequencer and its bind to the top level.
`include "calendar_date_sequence_top_assert.svh"

module cds_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [cds_pkg::DAY_W-1:0]         out_day,
  input logic [cds_pkg::MONTH_W-1:0]       out_month,
  input logic [cds_pkg::YEAR_IO_W-1:0]     out_year,
  input logic                              out_invalid,
  input logic                              out_last
);

  // A stalled result holds its payload
  `CDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_day) && $stable(out_month) && $stable(out_year) && $stable(out_invalid) && $stable(out_last))

  // An error result always ends the run
  `CDS_ASSERT_SAME(a_err_last, out_valid && out_invalid, out_last)

  // A request transfer closes the input until the run is done
  `CDS_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

  // A result that is not last leaves the run open
  `CDS_ASSERT_SAME(a_run_open, out_valid && !out_last, !in_ready)

endmodule

bind calendar_date_sequence_top cds_checker u_cds_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_day     (out_ch.out_day),
  .out_month   (out_ch.out_month),
  .out_year    (out_ch.out_year),
  .out_invalid (out_ch.invalid),
  .out_last    (out_ch.last)
);

[sim/cds_date_checker.sv]
// Checker for the date sequencer: predicts the date stream of each request and compares transfers.
module cds_date_checker (
  input  logic clk,
  input  logic rst_n,
  cds_in_if    in_ch,
  cds_out_if   out_ch,
  output int   fail_count,
  output int   waiting,
  output int   requests_seen,
  output int   dates_seen,
  output int   flagged_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                           MAX_COUNT = 63;
  localparam logic [cds_pkg::YEAR_IO_W-1:0] YEAR_MAX = '1;

  typedef struct {
    logic [cds_pkg::DAY_W-1:0]     day;
    logic [cds_pkg::MONTH_W-1:0]   month;
    logic [cds_pkg::YEAR_IO_W-1:0] year;
    logic                          invalid;
    logic                          last;
  } date_res_t;

  date_res_t expected_dates[$];

  function automatic logic is_leap(input logic [cds_pkg::YEAR_IO_W-1:0] y);
    int yr;
    yr = int'(y);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // Zero for a month code outside the calendar.
  function automatic logic [cds_pkg::DAY_W-1:0] days_in_month(
      input logic [cds_pkg::MONTH_W-1:0] m, input logic [cds_pkg::YEAR_IO_W-1:0] y);
    logic [cds_pkg::DAY_W-1:0] len;
    case (m) inside
      cds_pkg::JAN, cds_pkg::MAR, cds_pkg::MAY, cds_pkg::JUL, cds_pkg::AUG,
      cds_pkg::OCT, cds_pkg::DEC:
        len = cds_pkg::DAYS_31;
      cds_pkg::APR, cds_pkg::JUN, cds_pkg::SEP, cds_pkg::NOV:
        len = cds_pkg::DAYS_30;
      cds_pkg::FEB:
        len = is_leap(y) ? cds_pkg::DAYS_LEAP : cds_pkg::DAYS_FEB;
      default:
        len = '0;
    endcase
    return len;
  endfunction

  // Queue the echo, then one date per step until the count runs out or a check fails.
  task automatic predict_dates(input logic [cds_pkg::DAY_W-1:0] d,
                               input logic [cds_pkg::MONTH_W-1:0] m,
                               input logic [cds_pkg::YEAR_IO_W-1:0] y,
                               input logic [cds_pkg::COUNT_W-1:0] n);
    date_res_t                 r;
    int                        left;
    logic [cds_pkg::DAY_W-1:0] len;
    left = (int'(n) > MAX_COUNT) ? MAX_COUNT : int'(n);
    r.day     = d;
    r.month   = m;
    r.year    = y;
    r.invalid = 1'b0;
    r.last    = (left == 0);
    expected_dates.push_back(r);
    while (left > 0) begin
      len = days_in_month(r.month, r.year);
      if (r.year == '0 || len == '0 || r.day == '0 || r.day > len ||
          (r.month == cds_pkg::DEC && r.day == cds_pkg::DAYS_31 && r.year == YEAR_MAX)) begin
        r.invalid = 1'b1;
        r.last    = 1'b1;
        expected_dates.push_back(r);
        left = 0;
      end else begin
        if (r.day < len) begin
          r.day = r.day + 1'b1;
        end else begin
          r.day = cds_pkg::FIRST_DAY;
          if (r.month == cds_pkg::DEC) begin
            r.month = cds_pkg::JAN;
            r.year  = r.year + 1'b1;
          end else begin
            r.month = r.month + 1'b1;
          end
        end
        left   = left - 1;
        r.last = (left == 0);
        expected_dates.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got,
                             inout int errs);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  // Predict on each request transfer, compare each date transfer against the oldest prediction.
  always @(posedge clk) begin
    date_res_t want;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      expected_dates.delete();
      fail_count    <= 0;
      waiting       <= 0;
      requests_seen <= 0;
      dates_seen    <= 0;
      flagged_seen  <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_dates(in_ch.start_day, in_ch.start_month, in_ch.start_year, in_ch.count);
        requests_seen <= requests_seen + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        dates_seen   <= dates_seen + 1;
        flagged_seen <= flagged_seen + int'(out_ch.invalid);
        if (expected_dates.size() == 0) begin
          $error("date %0d/%0d/%0d transferred with no request outstanding",
                 out_ch.out_day, out_ch.out_month, out_ch.out_year);
          errs++;
        end else begin
          want = expected_dates.pop_front();
          check_field("out_day", want.day, out_ch.out_day, errs);
          check_field("out_month", want.month, out_ch.out_month, errs);
          check_field("out_year", want.year, out_ch.out_year, errs);
          check_field("invalid", want.invalid, out_ch.invalid, errs);
          check_field("last", want.last, out_ch.last, errs);
        end
      end
      fail_count <= fail_count + errs;
      waiting    <= expected_dates.size();
    end
  end

endmodule

[sim/tb_calendar_date_sequence_top.sv]
// Testbench top for the date sequencer: clock, reset, request stimulus, output stalls and verdict.
module tb_calendar_date_sequence_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_PER_PHASE = 110;
  localparam int DRAIN_CYCLES  = 40;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   idle_pct  = 0;
  int   stall_pct = 0;

  int fail_count, waiting, requests_seen, dates_seen, flagged_seen;

  cds_in_if  in_ch();
  cds_out_if out_ch();

  calendar_date_sequence_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cds_date_checker date_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .waiting       (waiting),
    .requests_seen (requests_seen),
    .dates_seen    (dates_seen),
    .flagged_seen  (flagged_seen)
  );

  always #2 clk = ~clk;

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stall the date channel at the current phase's rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Hold a request until it transfers; idle before it at the current phase's rate.
  task automatic send_request(input logic [cds_pkg::DAY_W-1:0] d,
                              input logic [cds_pkg::MONTH_W-1:0] m,
                              input logic [cds_pkg::YEAR_IO_W-1:0] y,
                              input logic [cds_pkg::COUNT_W-1:0] n);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.start_day   <= d;
    in_ch.start_month <= m;
    in_ch.start_year  <= y;
    in_ch.count       <= n;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Mostly plausible dates near month, century and range edges; the rest raw noise.
  task automatic send_random_request();
    logic [cds_pkg::DAY_W-1:0]     d;
    logic [cds_pkg::MONTH_W-1:0]   m;
    logic [cds_pkg::YEAR_IO_W-1:0] y;
    logic [cds_pkg::COUNT_W-1:0]   n;
    int                            pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      d = cds_pkg::DAY_W'($urandom());
      m = cds_pkg::MONTH_W'($urandom());
      y = cds_pkg::YEAR_IO_W'($urandom());
      n = cds_pkg::COUNT_W'($urandom());
    end else begin
      m = cds_pkg::MONTH_W'($urandom_range(cds_pkg::DEC, cds_pkg::JAN));
      d = cds_pkg::DAY_W'(($urandom_range(99) < 40) ? $urandom_range(28, 1) :
                                                       $urandom_range(31, 26));
      case ($urandom_range(3))
        0:       y = cds_pkg::YEAR_IO_W'($urandom_range(3000, 1));
        1:       y = cds_pkg::YEAR_IO_W'(100 * $urandom_range(655, 1));
        2: begin
          y = cds_pkg::YEAR_IO_W'($urandom_range(65535, 65530));
          if ($urandom_range(1)) begin
            m = cds_pkg::DEC;
            d = cds_pkg::DAY_W'($urandom_range(31, 25));
          end
        end
        default: y = cds_pkg::YEAR_IO_W'($urandom_range(65535, 1));
      endcase
      n = cds_pkg::COUNT_W'(($urandom_range(99) < 70) ? $urandom_range(63) :
                                                         $urandom_range(5));
    end
    send_request(d, m, y, n);
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.start_day   <= '0;
    in_ch.start_month <= '0;
    in_ch.start_year  <= '0;
    in_ch.count       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes, the unchecked echo and every check the stepper makes.
    send_request(5'd1, cds_pkg::JAN, 16'd2024, 6'd0);
    send_request(5'd0, 4'd0, 16'd0, 6'd0);
    send_request(5'd31, 4'd15, 16'd65535, 6'd63);
    send_request(5'd5, cds_pkg::MAR, 16'd0, 6'd2);
    send_request(5'd10, 4'd0, 16'd2020, 6'd1);
    send_request(5'd10, 4'd13, 16'd2020, 6'd1);
    send_request(5'd0, cds_pkg::JUN, 16'd2020, 6'd1);
    send_request(5'd31, cds_pkg::APR, 16'd2021, 6'd2);
    send_request(5'd29, cds_pkg::FEB, 16'd1900, 6'd1);
    send_request(5'd28, cds_pkg::FEB, 16'd2000, 6'd3);
    send_request(5'd28, cds_pkg::FEB, 16'd2100, 6'd2);
    send_request(5'd28, cds_pkg::FEB, 16'd2024, 6'd2);
    send_request(5'd30, cds_pkg::DEC, 16'd1999, 6'd3);
    send_request(5'd30, cds_pkg::DEC, 16'd65535, 6'd3);
    send_request(5'd31, cds_pkg::DEC, 16'd65535, 6'd0);
    send_request(5'd1, cds_pkg::JAN, 16'd2023, 6'd63);
    send_request(5'd30, cds_pkg::NOV, 16'd2023, 6'd1);
    send_request(5'd31, cds_pkg::JAN, 16'd1, 6'd40);
    send_request(5'd25, cds_pkg::DEC, 16'd65534, 6'd20);
    send_request(5'd31, cds_pkg::OCT, 16'd30000, 6'd32);

    // Random traffic under each idle/stall mix.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 57; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      repeat (RANDOM_PER_PHASE) send_random_request();
    end
    in_ch.valid <= 1'b0;
    stall_pct = 0;

    // Drain, then give the block time to show any stray date.
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d start requests and checked %0d dates, %0d flagged invalid,",
             requests_seen, dates_seen, flagged_seen);
    $display("across unthrottled, sender-idle, receiver-stall and mixed traffic.");
    if (fail_count == 0 && waiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
